[src/eida_pkg.sv]
package eida_pkg;

  localparam int ENTITY_COUNT    = 64;
  localparam int COMPONENT_COUNT = 32;
  localparam int ID_W            = 6;
  localparam int CNT_W           = 7;
  localparam int COMP_W          = 5;
  localparam int MASK_W          = 32;
  localparam int OP_W            = 3;

  typedef enum logic [OP_W-1:0] {
    OP_CREATE  = 3'd0,
    OP_DESTROY = 3'd1,
    OP_SET     = 3'd2,
    OP_CLEAR   = 3'd3,
    OP_READ    = 3'd4,
    OP_QUERY   = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_NOT_LIVE  = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_CREATE,
    S_QUERY,
    S_QEND
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [ID_W-1:0]   entity_id;
    logic [COMP_W-1:0] component_index;
    logic [MASK_W-1:0] query_mask;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0]   result_entity;
    logic [MASK_W-1:0] component_mask;
    logic [1:0]        status;
    logic              match_found;
    logic              last_result;
  } rsp_t;

  typedef struct packed {
    logic            live;
    logic [MASK_W-1:0] mask;
  } entry_t;

  typedef struct packed {
    logic            pop;
    logic            push;
    logic [ID_W-1:0] push_id;
  } qctl_t;

  typedef struct packed {
    logic            empty;
    logic [ID_W-1:0] head_id;
  } qstat_t;

  function automatic rsp_t mk_rsp(logic [ID_W-1:0] ent, logic [MASK_W-1:0] mask,
                                  status_t st, logic found, logic last);
    rsp_t r;
    r.result_entity  = ent;
    r.component_mask = mask;
    r.status         = st;
    r.match_found    = found;
    r.last_result    = last;
    return r;
  endfunction

endpackage

[src/eida_free_queue.sv]
module eida_free_queue import eida_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  qctl_t  ctl,
  output qstat_t st
);

  logic [ID_W-1:0]  mem [ENTITY_COUNT];
  logic [ID_W-1:0]  head;
  logic [ID_W-1:0]  tail;
  logic [CNT_W-1:0] count;
  logic             wrapped;
  logic [ID_W-1:0]  rd_q;
  logic [ID_W-1:0]  hd_q;
  logic             sel_q;

  function automatic logic [ID_W-1:0] nxt(logic [ID_W-1:0] p);
    return (p == ID_W'(ENTITY_COUNT - 1)) ? '0 : p + 1'b1;
  endfunction

  // slots never written since reset report their own index as the head ID
  assign st.empty   = (count == '0);
  assign st.head_id = sel_q ? rd_q : hd_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      tail    <= '0;
      count   <= CNT_W'(ENTITY_COUNT);
      wrapped <= 1'b0;
    end else begin
      if (ctl.pop) begin
        head <= nxt(head);
      end
      if (ctl.push) begin
        tail <= nxt(tail);
        if (tail == ID_W'(ENTITY_COUNT - 1)) begin
          wrapped <= 1'b1;
        end
      end
      if (ctl.push && !ctl.pop) begin
        count <= count + 1'b1;
      end else if (ctl.pop && !ctl.push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail] <= ctl.push_id;
    end
    rd_q  <= mem[head];
    hd_q  <= head;
    sel_q <= wrapped || (head < tail);
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(ENTITY_COUNT))
    else $error("free count above pool size");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    ctl.pop |-> count != '0)
    else $error("pop from empty free queue");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    (ctl.push && !ctl.pop) |=> count == $past(count) + 1'b1)
    else $error("push did not raise free count");

endmodule

[src/entity_id_allocator_signature_table.sv]
// channel | handshake          | payload
// request | req_valid/req_ready | req (req_t)
// result  | rsp_valid/rsp_ready | rsp (rsp_t)
//
// Destroy, set, clear, read and unused codes: accept, then table
// read-modify-write through the single read port and write port.
// Create: the popped ID's entry is read before its live bit is set.
// Query: one table read per ID plus one final item, taking longer
// while the result register is held by rsp_ready low.
// Reset: table entries read as zero until first written.
// req_ready is high only while no item is in progress.
module entity_id_allocator_signature_table import eida_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  state_t state;
  state_t state_next;

  logic [OP_W-1:0]   op_r;
  logic [ID_W-1:0]   id_r;
  logic [COMP_W-1:0] comp_r;
  logic [MASK_W-1:0] qmask_r;
  logic [ID_W-1:0]   new_id;

  entry_t mask_mem [ENTITY_COUNT];
  logic [ENTITY_COUNT-1:0] mask_vld;
  entry_t rd_data;
  logic   rd_vld;
  entry_t ent;

  logic [ID_W-1:0] rd_addr;
  logic            wr_en;
  logic [ID_W-1:0] wr_addr;
  entry_t          wr_data;
  logic            load_rsp;
  rsp_t            rsp_next;
  logic            cap_new;
  logic            q_start;

  logic [CNT_W-1:0] scan;
  logic [ID_W-1:0]  cmp_idx;
  logic             cmp_valid;
  logic             pend_valid;
  logic [ID_W-1:0]  pend_id;

  qctl_t  qctl;
  qstat_t qst;

  logic out_free;
  logic in_range;
  logic comp_ok;
  logic [MASK_W-1:0] comp_bit;
  logic hit;
  logic stall;
  logic issue_valid;

  eida_free_queue u_free_queue (
    .clk (clk),
    .rst (rst),
    .ctl (qctl),
    .st  (qst)
  );

  assign ent         = rd_vld ? rd_data : '0;
  assign out_free    = !rsp_valid || rsp_ready;
  assign in_range    = CNT_W'(id_r) < CNT_W'(ENTITY_COUNT);
  assign comp_ok     = CNT_W'(comp_r) < CNT_W'(COMPONENT_COUNT);
  assign comp_bit    = MASK_W'(1) << comp_r;
  assign hit         = cmp_valid && ((ent.mask & qmask_r) == qmask_r);
  assign stall       = hit && pend_valid && !out_free;
  assign issue_valid = scan < CNT_W'(ENTITY_COUNT);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (op_r)
          OP_CREATE: begin
            if (!qst.empty) begin
              state_next = S_CREATE;
            end else if (out_free) begin
              state_next = S_IDLE;
            end
          end
          OP_QUERY: begin
            if (qmask_r != '0) begin
              state_next = S_QUERY;
            end else if (out_free) begin
              state_next = S_IDLE;
            end
          end
          default: begin
            if (out_free) begin
              state_next = S_IDLE;
            end
          end
        endcase
      end
      S_CREATE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_QUERY: begin
        if (!stall && !issue_valid) begin
          state_next = S_QEND;
        end
      end
      S_QEND: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    rd_addr   = id_r;
    wr_en     = 1'b0;
    wr_addr   = id_r;
    wr_data   = ent;
    load_rsp  = 1'b0;
    rsp_next  = mk_rsp('0, '0, ST_OK, 1'b0, 1'b1);
    cap_new   = 1'b0;
    q_start   = 1'b0;
    qctl      = '0;
    qctl.push_id = id_r;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        rd_addr   = req.entity_id;
      end
      S_EXEC: begin
        case (op_r)
          OP_CREATE: begin
            if (qst.empty) begin
              load_rsp = out_free;
              rsp_next = mk_rsp('0, '0, ST_EXHAUSTED, 1'b0, 1'b1);
            end else begin
              rd_addr = qst.head_id;
              cap_new = 1'b1;
            end
          end
          OP_DESTROY: begin
            load_rsp = out_free;
            if (!in_range || !ent.live) begin
              rsp_next = mk_rsp('0, '0, ST_NOT_LIVE, 1'b0, 1'b1);
            end else begin
              wr_en     = out_free;
              wr_data   = '0;
              qctl.push = out_free;
            end
          end
          OP_SET, OP_CLEAR: begin
            load_rsp = out_free;
            if (!in_range) begin
              rsp_next = mk_rsp('0, '0, ST_NOT_LIVE, 1'b0, 1'b1);
            end else begin
              wr_en = out_free && comp_ok;
              if (op_r == OP_SET) begin
                wr_data.mask = ent.mask | comp_bit;
              end else begin
                wr_data.mask = ent.mask & ~comp_bit;
              end
            end
          end
          OP_READ: begin
            load_rsp = out_free;
            if (!in_range || !ent.live) begin
              rsp_next = mk_rsp('0, '0, ST_NOT_LIVE, 1'b0, 1'b1);
            end else begin
              rsp_next = mk_rsp('0, ent.mask, ST_OK, 1'b0, 1'b1);
            end
          end
          OP_QUERY: begin
            if (qmask_r == '0) begin
              load_rsp = out_free;
              rsp_next = mk_rsp('0, '0, ST_EMPTY, 1'b0, 1'b1);
            end else begin
              q_start = 1'b1;
            end
          end
          default: begin
            load_rsp = out_free;
          end
        endcase
      end
      S_CREATE: begin
        rd_addr      = new_id;
        wr_addr      = new_id;
        wr_data.live = 1'b1;
        wr_en        = out_free;
        qctl.pop     = out_free;
        load_rsp     = out_free;
        rsp_next     = mk_rsp(new_id, '0, ST_OK, 1'b0, 1'b1);
      end
      S_QUERY: begin
        rd_addr  = stall ? cmp_idx : scan[ID_W-1:0];
        // a new match releases the one held back, which is then not last
        load_rsp = hit && pend_valid && out_free;
        rsp_next = mk_rsp(pend_id, '0, ST_OK, 1'b1, 1'b0);
      end
      S_QEND: begin
        load_rsp = out_free;
        if (pend_valid) begin
          rsp_next = mk_rsp(pend_id, '0, ST_OK, 1'b1, 1'b1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rsp_valid  <= 1'b0;
      mask_vld   <= '0;
      scan       <= '0;
      cmp_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (wr_en) begin
        mask_vld[wr_addr] <= 1'b1;
      end
      if (q_start) begin
        scan       <= '0;
        cmp_valid  <= 1'b0;
        pend_valid <= 1'b0;
      end else if (state == S_QUERY) begin
        cmp_valid <= stall || issue_valid;
        if (!stall && issue_valid) begin
          scan <= scan + 1'b1;
        end
        if (hit && !stall) begin
          pend_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      op_r    <= req.operation;
      id_r    <= req.entity_id;
      comp_r  <= req.component_index;
      qmask_r <= req.query_mask;
    end
    if (cap_new) begin
      new_id <= qst.head_id;
    end
    if (load_rsp) begin
      rsp <= rsp_next;
    end
    if (state == S_QUERY) begin
      cmp_idx <= rd_addr;
      if (hit && !stall) begin
        pend_id <= cmp_idx;
      end
    end
    rd_vld <= mask_vld[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mask_mem[wr_addr] <= wr_data;
    end
    rd_data <= mask_mem[rd_addr];
  end

  a_wr_state: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_EXEC || state == S_CREATE))
    else $error("table write outside an update step");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_QUERY && stall) |=> $stable(cmp_idx) && cmp_valid)
    else $error("query scan moved while a match was held");

  a_qend_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_QEND && out_free) |=> rsp_valid && rsp.last_result)
    else $error("query did not end with a last item");

  a_pop_live: assert property (@(posedge clk) disable iff (rst)
    qctl.pop |-> wr_en && wr_data.live && !qst.empty)
    else $error("allocation without live update");

endmodule
